// ----- design/gapp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the grid A* path planner.
// No dependencies.
package gapp_pkg;

	localparam int GRID_COLS_DEF = 32;
	localparam int GRID_ROWS_DEF = 32;

	// configuration port
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 6'd32;

	localparam int DIM_W   = 9;   // holds a grid dimension up to 256
	localparam int COORD_W = 5;
	localparam int PLEN_W  = 10;

	localparam int COST_STRAIGHT = 100;
	localparam int COST_DIAG     = 141;

	// operations
	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// neighbor offset codes
	localparam logic [1:0] D_NEG  = 2'd0;
	localparam logic [1:0] D_ZERO = 2'd1;
	localparam logic [1:0] D_POS  = 2'd2;

	// neighbor k: column offset outer, row offset inner, center skipped
	localparam logic [1:0] NB_DX [8] = '{D_NEG, D_NEG, D_NEG, D_ZERO, D_ZERO,
		D_POS, D_POS, D_POS};
	localparam logic [1:0] NB_DY [8] = '{D_NEG, D_ZERO, D_POS, D_NEG, D_POS,
		D_NEG, D_ZERO, D_POS};
	// straight neighbors beside a diagonal: (dx,0) and (0,dy)
	localparam logic [2:0] NB_OX [8] = '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd6, 3'd6, 3'd6};
	localparam logic [2:0] NB_OY [8] = '{3'd3, 3'd3, 3'd4, 3'd3, 3'd4,
		3'd3, 3'd3, 3'd4};

	typedef struct packed {
		logic [1:0]         operation;
		logic [COORD_W-1:0] first_col;
		logic [COORD_W-1:0] first_row;
		logic [COORD_W-1:0] second_col;
		logic [COORD_W-1:0] second_row;
		logic               new_walkable;
		logic [PLEN_W-1:0]  path_index;
	} item_t;

	typedef struct packed {
		logic               path_found;
		logic [PLEN_W-1:0]  path_length;
		logic [COORD_W-1:0] cell_col;
		logic [COORD_W-1:0] cell_row;
		logic               cell_walkable;
	} result_t;

	typedef struct packed {
		logic latch_in;
		logic walk_init;
		logic disp;
		logic search_begin;
		logic clr_sweep;
		logic seed;
		logic scan_init;
		logic scan_run;
		logic close_cur;
		logic walk_nb;
		logic nb_rd;
		logic nb_eval;
		logic path_init;
		logic path_a;
		logic path_b;
		logic path_done;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic       sweep_last;
		logic [1:0] op;
		logic       ends_ok;
		logic       open_empty;
		logic       scan_done;
		logic       best_is_target;
		logic       walk_last;
		logic       nb_last;
		logic       path_end;
		logic       out_free;
	} stat_t;

endpackage

// ----- design/grid_astar_path_planner.sv -----
`timescale 1ns / 1ps
// Top level of the grid A* path planner: sequencer plus datapath.
// Depends on gapp_pkg, gapp_ctrl and gapp_dp.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------
//  item     | item_valid / item_stall    | item   (gapp_pkg::item_t)
//  result   | result_valid / result_stall| result (gapp_pkg::result_t)
//  config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// After reset the walk map is swept to all-walkable, one cell a cycle, over every
// cell address (GRID_COLS*GRID_ROWS rounded up to powers of two); items stall meanwhile.
// Set, query and read-path pass through the dispatch and response states before
// result_valid rises; the next item is taken only once the sequencer is back in idle.
// A search makes one clear pass over the cell memory (every address, as in the reset sweep),
// then per expanded cell an open-list scan and check (one memory read per list entry), a
// walk-map read of the eight neighbors and an update of each, then the path trace.
// One item is in flight at a time; a finished result waits in the output register
// while the next item is taken.
module grid_astar_path_planner #(
	parameter int GRID_COLS = gapp_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gapp_pkg::GRID_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  gapp_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output gapp_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [gapp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gapp_pkg::CFG_W-1:0]     cfg_data
);
	import gapp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// state machine: owns item_stall and sequences every memory pass
	gapp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// memories, open list scan, neighbor update, path trace, result register
	gapp_dp #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- design/gapp_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the grid A* path planner: one state machine issuing datapath commands.
// Depends on gapp_pkg.
module gapp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  gapp_pkg::stat_t stat,
	output gapp_pkg::cmd_t  cmd
);
	import gapp_pkg::*;

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISP     = 4'd2;
	localparam logic [3:0] S_RESP     = 4'd3;
	localparam logic [3:0] S_CLR      = 4'd4;
	localparam logic [3:0] S_SEED     = 4'd5;
	localparam logic [3:0] S_SCAN0    = 4'd6;
	localparam logic [3:0] S_SCAN     = 4'd7;
	localparam logic [3:0] S_CHECK    = 4'd8;
	localparam logic [3:0] S_WALK     = 4'd9;
	localparam logic [3:0] S_WALK_END = 4'd10;
	localparam logic [3:0] S_NB       = 4'd11;
	localparam logic [3:0] S_NBEV     = 4'd12;
	localparam logic [3:0] S_PATH_A   = 4'd13;
	localparam logic [3:0] S_PATH_B   = 4'd14;

	logic [3:0] state_q, state_nxt;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.walk_init = 1'b1;
				if (stat.sweep_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch_in = 1'b1;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				cmd.disp = 1'b1;
				if (stat.op == OP_FIND) begin
					cmd.search_begin = 1'b1;
					state_nxt = stat.ends_ok ? S_CLR : S_RESP;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_CLR: begin
				cmd.clr_sweep = 1'b1;
				if (stat.sweep_last) state_nxt = S_SEED;
			end
			S_SEED: begin
				cmd.seed = 1'b1;
				state_nxt = S_SCAN0;
			end
			S_SCAN0: begin
				cmd.scan_init = 1'b1;
				state_nxt = stat.open_empty ? S_RESP : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (stat.best_is_target) begin
					cmd.path_init = 1'b1;
					state_nxt = S_PATH_A;
				end else begin
					cmd.close_cur = 1'b1;
					state_nxt = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_nb = 1'b1;
				if (stat.walk_last) state_nxt = S_WALK_END;
			end
			S_WALK_END: state_nxt = S_NB;
			S_NB: begin
				cmd.nb_rd = 1'b1;
				state_nxt = S_NBEV;
			end
			S_NBEV: begin
				cmd.nb_eval = 1'b1;
				state_nxt = stat.nb_last ? S_SCAN0 : S_NB;
			end
			S_PATH_A: begin
				if (stat.path_end) begin
					cmd.path_done = 1'b1;
					state_nxt = S_RESP;
				end else begin
					cmd.path_a = 1'b1;
					state_nxt = S_PATH_B;
				end
			end
			S_PATH_B: begin
				cmd.path_b = 1'b1;
				state_nxt = S_PATH_A;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_nxt;
	end

endmodule

// ----- design/gapp_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the grid A* path planner: map, search and path memories, counters, result.
// Depends on gapp_pkg; driven by gapp_ctrl.
module gapp_dp #(
	parameter int GRID_COLS = gapp_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gapp_pkg::GRID_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gapp_pkg::item_t                 item,
	input  logic                            cfg_we,
	input  logic [gapp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gapp_pkg::CFG_W-1:0]      cfg_data,
	input  gapp_pkg::cmd_t                  cmd,
	output gapp_pkg::stat_t                 stat,
	output logic                            result_valid,
	input  logic                            result_stall,
	output gapp_pkg::result_t               result
);
	import gapp_pkg::*;

	localparam int CW     = $clog2(GRID_COLS);
	localparam int RW     = $clog2(GRID_ROWS);
	localparam int AW     = CW + RW;
	localparam int DEPTH  = 1 << AW;
	localparam int CNT_W  = AW + 1;
	localparam int COST_W = $clog2(DEPTH * COST_DIAG + 1);
	localparam int F_W    = COST_W + 1;
	localparam int CMP_W  = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;
	localparam int CM_W   = COST_W + 2;   // {cost, closed, open}

	function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] c,
		input logic [COORD_W-1:0] r);
		cell_addr = {RW'(r), CW'(c)};
	endfunction

	function automatic logic [COST_W-1:0] octile(input logic [AW-1:0] a,
		input logic [AW-1:0] b);
		logic [DIM_W-1:0] dx, dy, lo, hi;
		dx = (a[CW-1:0] > b[CW-1:0]) ? DIM_W'(a[CW-1:0] - b[CW-1:0])
			: DIM_W'(b[CW-1:0] - a[CW-1:0]);
		dy = (a[AW-1:CW] > b[AW-1:CW]) ? DIM_W'(a[AW-1:CW] - b[AW-1:CW])
			: DIM_W'(b[AW-1:CW] - a[AW-1:CW]);
		lo = (dx < dy) ? dx : dy;
		hi = (dx < dy) ? dy : dx;
		octile = COST_W'(COST_DIAG * lo + COST_STRAIGHT * (hi - lo));
	endfunction

	// configuration and latched item
	logic [CFG_W-1:0] cols_q, rows_q;
	logic [DIM_W-1:0] eff_w, eff_h;
	item_t            item_q;
	logic             first_ok, second_ok;
	logic [AW-1:0]    start_a, tgt_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_DIM_RESET;
			rows_q <= CFG_DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_COLS) cols_q <= cfg_data;
			if (cfg_index == CFG_ROWS) rows_q <= cfg_data;
		end
	end

	always_comb begin
		if (cols_q == '0) eff_w = DIM_W'(1);
		else if (DIM_W'(cols_q) > DIM_W'(GRID_COLS)) eff_w = DIM_W'(GRID_COLS);
		else eff_w = DIM_W'(cols_q);
		if (rows_q == '0) eff_h = DIM_W'(1);
		else if (DIM_W'(rows_q) > DIM_W'(GRID_ROWS)) eff_h = DIM_W'(GRID_ROWS);
		else eff_h = DIM_W'(rows_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) item_q <= item;
	end

	assign first_ok  = (DIM_W'(item_q.first_col) < eff_w) && (DIM_W'(item_q.first_row) < eff_h);
	assign second_ok = (DIM_W'(item_q.second_col) < eff_w)
		&& (DIM_W'(item_q.second_row) < eff_h);
	assign start_a = cell_addr(item_q.first_col, item_q.first_row);
	assign tgt_a   = cell_addr(item_q.second_col, item_q.second_row);

	// counters and search registers
	logic [AW-1:0]     sweep_q;
	logic [CNT_W-1:0]  ocnt_q, live_q, scan_i_q, j_q, len_q;
	logic              found_q;
	logic              scan_v_s1, scan_v_s2;
	logic [AW-1:0]     cell_s2;
	logic [COST_W-1:0] h_s2;
	logic              best_v_q;
	logic [AW-1:0]     best_cell_q;
	logic [COST_W-1:0] best_g_q;
	logic [F_W-1:0]    best_f_q, scan_f;
	logic [2:0]        k_q, walk_k_s1;
	logic              walk_v_s1;
	logic [7:0]        wb_q;
	logic [AW-1:0]     c_q;
	logic              scan_issue;

	// memories
	logic            walk_mem_q [DEPTH];
	logic [CM_W-1:0] cm_mem_q [DEPTH];
	logic [AW-1:0]   par_mem_q [DEPTH];
	logic [AW-1:0]   ord_mem_q [DEPTH];
	logic [AW-1:0]   path_mem_q [DEPTH];

	logic            walk_we, walk_wd, walk_re, walk_rd_q;
	logic [AW-1:0]   walk_wa, walk_ra;
	logic            cm_we, cm_re;
	logic [AW-1:0]   cm_wa, cm_ra;
	logic [CM_W-1:0] cm_wd, cm_rd_q;
	logic            par_we, par_re;
	logic [AW-1:0]   par_rd_q;
	logic            ord_we;
	logic [AW-1:0]   ord_wa, ord_wd, ord_rd_q;
	logic            path_we, path_re;
	logic [AW-1:0]   path_ra, path_rd_q;

	logic [COST_W-1:0] cm_cost;
	logic              cm_closed, cm_open;
	assign cm_cost   = cm_rd_q[CM_W-1:2];
	assign cm_closed = cm_rd_q[1];
	assign cm_open   = cm_rd_q[0];

	// neighbors of the cell being expanded
	logic [AW-1:0] nb_a [8];
	logic [7:0]    ing;

	always_comb begin
		logic [CW-1:0] cx, nx;
		logic [RW-1:0] cy, ny;
		logic          okx, oky;
		cx = best_cell_q[CW-1:0];
		cy = best_cell_q[AW-1:CW];
		for (int k = 0; k < 8; k++) begin
			case (NB_DX[k])
				D_NEG: begin okx = (cx != '0); nx = cx - CW'(1); end
				D_POS: begin okx = (DIM_W'(cx) + DIM_W'(1)) < eff_w; nx = cx + CW'(1); end
				default: begin okx = 1'b1; nx = cx; end
			endcase
			case (NB_DY[k])
				D_NEG: begin oky = (cy != '0); ny = cy - RW'(1); end
				D_POS: begin oky = (DIM_W'(cy) + DIM_W'(1)) < eff_h; ny = cy + RW'(1); end
				default: begin oky = 1'b1; ny = cy; end
			endcase
			ing[k]  = okx && oky;
			nb_a[k] = {ny, nx};
		end
	end

	logic              nb_diag, nb_elig, nb_upd;
	logic [COST_W-1:0] g_new;
	assign nb_diag = (NB_DX[k_q] != D_ZERO) && (NB_DY[k_q] != D_ZERO);
	assign g_new   = best_g_q + (nb_diag ? COST_W'(COST_DIAG) : COST_W'(COST_STRAIGHT));
	assign nb_elig = wb_q[k_q] && !cm_closed
		&& (!nb_diag || (wb_q[NB_OX[k_q]] && wb_q[NB_OY[k_q]]));
	assign nb_upd  = cmd.nb_eval && nb_elig && ((g_new < cm_cost) || !cm_open);

	assign scan_issue = cmd.scan_run && (scan_i_q < ocnt_q);
	assign scan_f     = F_W'(cm_cost) + F_W'(h_s2);

	logic pi_lt;
	assign pi_lt = CMP_W'(item_q.path_index) < CMP_W'(len_q);

	// port steering
	always_comb begin
		walk_we = 1'b0;
		walk_wa = sweep_q;
		walk_wd = 1'b1;
		if (cmd.walk_init) begin
			walk_we = 1'b1;
		end else if (cmd.disp && item_q.operation == OP_SET && first_ok) begin
			walk_we = 1'b1;
			walk_wa = start_a;
			walk_wd = item_q.new_walkable;
		end
		walk_re = (cmd.disp && item_q.operation == OP_QUERY) || cmd.walk_nb;
		walk_ra = cmd.walk_nb ? nb_a[k_q] : start_a;

		cm_we = 1'b1;
		cm_wa = sweep_q;
		cm_wd = {{COST_W{1'b1}}, 2'b00};
		if (cmd.clr_sweep) begin
			cm_wa = sweep_q;
		end else if (cmd.seed) begin
			cm_wa = start_a;
			cm_wd = {COST_W'(0), 2'b01};
		end else if (cmd.close_cur) begin
			cm_wa = best_cell_q;
			cm_wd = {best_g_q, 2'b10};
		end else if (nb_upd) begin
			cm_wa = nb_a[k_q];
			cm_wd = {g_new, 2'b01};
		end else begin
			cm_we = 1'b0;
		end
		cm_re = (cmd.scan_run && scan_v_s1) || cmd.nb_rd;
		cm_ra = cmd.nb_rd ? nb_a[k_q] : ord_rd_q;

		par_we = nb_upd;
		par_re = cmd.path_a;

		ord_we = cmd.seed || (nb_upd && !cm_open);
		ord_wa = cmd.seed ? '0 : ocnt_q[AW-1:0];
		ord_wd = cmd.seed ? start_a : nb_a[k_q];

		path_we = cmd.path_a;
		path_re = cmd.disp && item_q.operation == OP_READ;
		path_ra = AW'(len_q - CNT_W'(1) - CNT_W'(item_q.path_index));
	end

	always_ff @(posedge clk) begin
		if (walk_we) walk_mem_q[walk_wa] <= walk_wd;
		if (walk_re) walk_rd_q <= walk_mem_q[walk_ra];
	end

	always_ff @(posedge clk) begin
		if (cm_we) cm_mem_q[cm_wa] <= cm_wd;
		if (cm_re) cm_rd_q <= cm_mem_q[cm_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem_q[nb_a[k_q]] <= best_cell_q;
		if (par_re) par_rd_q <= par_mem_q[c_q];
	end

	always_ff @(posedge clk) begin
		if (ord_we) ord_mem_q[ord_wa] <= ord_wd;
		if (scan_issue) ord_rd_q <= ord_mem_q[scan_i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (path_we) path_mem_q[j_q[AW-1:0]] <= c_q;
		if (path_re) path_rd_q <= path_mem_q[path_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			ocnt_q    <= '0;
			live_q    <= '0;
			scan_i_q  <= '0;
			scan_v_s1 <= 1'b0;
			scan_v_s2 <= 1'b0;
			best_v_q  <= 1'b0;
			k_q       <= '0;
			walk_v_s1 <= 1'b0;
			j_q       <= '0;
			len_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.walk_init || cmd.clr_sweep) sweep_q <= sweep_q + AW'(1);

			if (cmd.seed) begin
				ocnt_q <= CNT_W'(1);
				live_q <= CNT_W'(1);
			end else if (cmd.close_cur) begin
				live_q <= live_q - CNT_W'(1);
			end else if (nb_upd && !cm_open) begin
				ocnt_q <= ocnt_q + CNT_W'(1);
				live_q <= live_q + CNT_W'(1);
			end

			if (cmd.scan_init) scan_i_q <= '0;
			else if (scan_issue) scan_i_q <= scan_i_q + CNT_W'(1);
			scan_v_s1 <= scan_issue;
			scan_v_s2 <= scan_v_s1 && cmd.scan_run;

			if (cmd.scan_init) best_v_q <= 1'b0;
			else if (scan_v_s2 && !cm_closed && (!best_v_q || scan_f < best_f_q))
				best_v_q <= 1'b1;

			if (cmd.close_cur) k_q <= '0;
			else if (cmd.walk_nb || cmd.nb_eval) k_q <= k_q + 3'd1;
			walk_v_s1 <= cmd.walk_nb;

			if (cmd.path_init) j_q <= '0;
			else if (cmd.path_a) j_q <= j_q + CNT_W'(1);

			if (cmd.search_begin) begin
				found_q <= 1'b0;
				len_q   <= '0;
			end else if (cmd.path_done) begin
				found_q <= 1'b1;
				len_q   <= j_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cell_s2   <= ord_rd_q;
		h_s2      <= octile(ord_rd_q, tgt_a);
		walk_k_s1 <= k_q;
		if (scan_v_s2 && !cm_closed && (!best_v_q || scan_f < best_f_q)) begin
			best_cell_q <= cell_s2;
			best_g_q    <= cm_cost;
			best_f_q    <= scan_f;
		end
		if (walk_v_s1) wb_q[walk_k_s1] <= walk_rd_q && ing[walk_k_s1];
		if (cmd.path_init) c_q <= tgt_a;
		else if (cmd.path_b) c_q <= par_rd_q;
	end

	// status
	always_comb begin
		stat.sweep_last     = &sweep_q;
		stat.op             = item_q.operation;
		stat.ends_ok        = first_ok && second_ok;
		stat.open_empty     = (live_q == '0);
		stat.scan_done      = (scan_i_q == ocnt_q) && !scan_v_s1 && !scan_v_s2;
		stat.best_is_target = (best_cell_q == tgt_a);
		stat.walk_last      = (k_q == 3'd7);
		stat.nb_last        = (k_q == 3'd7);
		stat.path_end       = (c_q == start_a) || (j_q == CNT_W'(DEPTH));
		stat.out_free       = !result_valid || !result_stall;
	end

	// result assembly and output register
	result_t res;
	always_comb begin
		res = '0;
		unique case (item_q.operation)
			OP_SET: res = '0;
			OP_QUERY: res.cell_walkable = first_ok && walk_rd_q;
			OP_FIND: begin
				res.path_found  = found_q;
				res.path_length = PLEN_W'(len_q);
			end
			OP_READ: begin
				res.path_length = PLEN_W'(len_q);
				if (pi_lt) begin
					res.path_found = 1'b1;
					res.cell_col   = COORD_W'(path_rd_q[CW-1:0]);
					res.cell_row   = COORD_W'(path_rd_q[AW-1:CW]);
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else if (cmd.load_out) result_valid <= 1'b1;
		else if (!result_stall) result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) result <= res;
	end

	a_live_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= ocnt_q)
		else $error("open entries exceed list length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result_valid || !result_stall))
		else $error("result register overwritten while stalled");

	a_close_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close_cur |-> (best_v_q && best_cell_q != tgt_a))
		else $error("closing without a selected open cell");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_init |-> (!scan_v_s1 && !scan_v_s2))
		else $error("scan restarted with reads in flight");

endmodule
